>>> rtl/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

  // Window geometry: sequence numbers run 0..MaxSeq
  localparam int MaxSeq      = 7;
  localparam int WinSlots    = MaxSeq + 1;
  localparam int SeqW        = $clog2(WinSlots);
  localparam int PayloadBits = 32;
  localparam int QueueDepth  = 2;

  // Request type codes on the input channel
  localparam logic [1:0] REQ_SEND    = 2'd0;
  localparam logic [1:0] REQ_FRAME   = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_XMIT    = 2'd1,
    KIND_DELIVER = 2'd2
  } kind_e;

  // Classified commands handed from front to back
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_SEND,
    CMD_FRAME,
    CMD_TIMEOUT
  } cmd_e;

  typedef struct packed {
    cmd_e            kind;
    logic [SeqW-1:0] seq;
    logic [SeqW-1:0] ack;
  } cmd_t;

  // Circular successor of a sequence number
  function automatic logic [SeqW-1:0] seq_inc(input logic [SeqW-1:0] s);
    seq_inc = (s == SeqW'(MaxSeq)) ? '0 : s + SeqW'(1);
  endfunction

  // True when b lies in the circular window [a, c)
  function automatic logic between(input logic [SeqW-1:0] a,
                                   input logic [SeqW-1:0] b,
                                   input logic [SeqW-1:0] c);
    between = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
              ((b < c) && (c < a));
  endfunction

endpackage

>>> rtl/gbn_front.sv
`timescale 1ns / 1ps

module gbn_front #(
  parameter int PAYLOAD_BITS = gbn_pkg::PayloadBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              req_type_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  input  logic [2:0]              rx_seq_i,
  input  logic [2:0]              rx_ack_i,
  input  logic                    rx_crc_ok_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output gbn_pkg::cmd_t           cmd_o,
  output logic [PAYLOAD_BITS-1:0] pay_o
);
  import gbn_pkg::*;

  logic                    fv_q;
  cmd_t                    cmd_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  cmd_t                    cmd_d;

  // Classify the request; a bad frame or an unknown code becomes a no-op
  always_comb begin
    cmd_d.seq = SeqW'(rx_seq_i);
    cmd_d.ack = SeqW'(rx_ack_i);
    unique case (req_type_i)
      REQ_SEND:    cmd_d.kind = CMD_SEND;
      REQ_FRAME:   cmd_d.kind = rx_crc_ok_i ? CMD_FRAME : CMD_NOP;
      REQ_TIMEOUT: cmd_d.kind = CMD_TIMEOUT;
      default:     cmd_d.kind = CMD_NOP;
    endcase
  end

  assign in_ready_o   = !fv_q || push_ready_i;
  assign push_valid_o = fv_q;
  assign cmd_o        = cmd_q;
  assign pay_o        = pay_q;

  // Holding register in front of the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q  <= 1'b0;
      cmd_q <= '0;
      pay_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      fv_q  <= 1'b1;
      cmd_q <= cmd_d;
      pay_q <= payload_i;
    end else if (push_ready_i) begin
      fv_q  <= 1'b0;
    end
  end

endmodule

>>> rtl/gbn_queue.sv
`timescale 1ns / 1ps

module gbn_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gbn_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slots_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/gbn_back.sv
`timescale 1ns / 1ps

module gbn_back #(
  parameter int PAYLOAD_BITS = gbn_pkg::PayloadBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_valid_i,
  output logic                    pop_ready_o,
  input  gbn_pkg::cmd_t           cmd_i,
  input  logic [PAYLOAD_BITS-1:0] pay_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output gbn_pkg::kind_e          out_kind_o,
  output logic [2:0]              out_seq_o,
  output logic [2:0]              out_ack_o,
  output logic [PAYLOAD_BITS-1:0] out_payload_o,
  output logic [2:0]              outstanding_count_o,
  output logic                    accept_more_o,
  output logic                    refused_o,
  output logic                    last_o
);
  import gbn_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACK,
    S_READ,
    S_EMIT
  } state_e;

  state_e                  state_q;
  logic [SeqW-1:0]         nts_q, ae_q, fe_q, outs_q, cnt_q, rack_q;
  logic                    deliver_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  // Output register
  logic                    ov_q;
  kind_e                   okind_q;
  logic [SeqW-1:0]         oseq_q, oack_q, ocnt_q;
  logic [PAYLOAD_BITS-1:0] opay_q;
  logic                    omore_q, oref_q, olast_q;

  // Window store
  logic [PAYLOAD_BITS-1:0] win_mem [WinSlots];
  logic [PAYLOAD_BITS-1:0] rdata_q;
  logic                    win_we;

  logic                    can_load;
  logic                    window_full;
  logic [SeqW-1:0]         piggy;
  logic                    ack_hit;
  logic                    last_frame;
  logic                    pop_fire;
  logic                    send_ok;
  logic                    ov_set;

  assign can_load    = !ov_q || out_ready_i;
  assign window_full = (outs_q >= SeqW'(MaxSeq));
  assign piggy       = (fe_q == '0) ? SeqW'(MaxSeq) : fe_q - SeqW'(1);
  assign ack_hit     = (outs_q != '0) && between(ae_q, rack_q, nts_q);
  assign last_frame  = ((cnt_q + SeqW'(1)) == outs_q);
  assign pop_ready_o = (state_q == S_IDLE) && can_load;
  assign pop_fire    = pop_valid_i && pop_ready_o;
  assign send_ok     = (cmd_i.kind == CMD_SEND) && !window_full;
  assign win_we      = pop_fire && send_ok;

  // Result register load: single results on pop, ack completion, each resend
  always_comb begin
    ov_set = 1'b0;
    unique case (state_q)
      S_IDLE:  ov_set = pop_fire && (cmd_i.kind != CMD_FRAME) &&
                        ((cmd_i.kind != CMD_TIMEOUT) || (outs_q == '0));
      S_ACK:   ov_set = !ack_hit && can_load;
      S_READ:  ov_set = 1'b0;
      S_EMIT:  ov_set = can_load;
      default: ov_set = 1'b0;
    endcase
  end

  // Store write on send, registered read at the retransmit pointer
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[nts_q] <= pay_i;
    end
    rdata_q <= win_mem[nts_q];
  end

  // Protocol sequencer with its result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      nts_q     <= '0;
      ae_q      <= '0;
      fe_q      <= '0;
      outs_q    <= '0;
      cnt_q     <= '0;
      rack_q    <= '0;
      deliver_q <= 1'b0;
      pay_q     <= '0;
      ov_q      <= 1'b0;
      okind_q   <= KIND_NONE;
      oseq_q    <= '0;
      oack_q    <= '0;
      ocnt_q    <= '0;
      opay_q    <= '0;
      omore_q   <= 1'b0;
      oref_q    <= 1'b0;
      olast_q   <= 1'b0;
    end else begin
      ov_q <= ov_set || (ov_q && !out_ready_i);
      unique case (state_q)
        S_IDLE: begin
          if (pop_fire) begin
            // single result: a transmit on an accepted send, else empty
            okind_q <= send_ok ? KIND_XMIT : KIND_NONE;
            oseq_q  <= send_ok ? nts_q : '0;
            oack_q  <= send_ok ? piggy : '0;
            opay_q  <= send_ok ? pay_i : '0;
            ocnt_q  <= send_ok ? outs_q + SeqW'(1) : outs_q;
            omore_q <= send_ok ? ((outs_q + SeqW'(1)) < SeqW'(MaxSeq)) : !window_full;
            oref_q  <= (cmd_i.kind == CMD_SEND) && window_full;
            olast_q <= 1'b1;
            unique case (cmd_i.kind)
              CMD_SEND: begin
                if (!window_full) begin
                  outs_q <= outs_q + SeqW'(1);
                  nts_q  <= seq_inc(nts_q);
                end
              end
              CMD_FRAME: begin
                deliver_q <= (cmd_i.seq == fe_q);
                if (cmd_i.seq == fe_q) begin
                  fe_q <= seq_inc(fe_q);
                end
                rack_q  <= cmd_i.ack;
                pay_q   <= pay_i;
                state_q <= S_ACK;
              end
              CMD_TIMEOUT: begin
                if (outs_q != '0) begin
                  nts_q   <= ae_q;
                  cnt_q   <= '0;
                  state_q <= S_READ;
                end
              end
              CMD_NOP: begin
                // empty result loaded above
              end
            endcase
          end
        end
        S_ACK: begin
          // free one acknowledged frame per cycle
          if (ack_hit) begin
            outs_q <= outs_q - SeqW'(1);
            ae_q   <= seq_inc(ae_q);
          end else if (can_load) begin
            okind_q <= deliver_q ? KIND_DELIVER : KIND_NONE;
            oseq_q  <= '0;
            oack_q  <= '0;
            opay_q  <= deliver_q ? pay_q : '0;
            ocnt_q  <= outs_q;
            omore_q <= !window_full;
            oref_q  <= 1'b0;
            olast_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (can_load) begin
            okind_q <= KIND_XMIT;
            oseq_q  <= nts_q;
            oack_q  <= piggy;
            opay_q  <= rdata_q;
            ocnt_q  <= outs_q;
            omore_q <= !window_full;
            oref_q  <= 1'b0;
            olast_q <= last_frame;
            nts_q   <= seq_inc(nts_q);
            cnt_q   <= cnt_q + SeqW'(1);
            state_q <= last_frame ? S_IDLE : S_READ;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o         = ov_q;
  assign out_kind_o          = okind_q;
  assign out_seq_o           = 3'(oseq_q);
  assign out_ack_o           = 3'(oack_q);
  assign out_payload_o       = opay_q;
  assign outstanding_count_o = 3'(ocnt_q);
  assign accept_more_o       = omore_q;
  assign refused_o           = oref_q;
  assign last_o              = olast_q;

endmodule

>>> rtl/go_back_n_link_control.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// request   in         in_valid_i / in_ready_o      req_type, payload, rx_seq, rx_ack, rx_crc_ok
// result    out        out_valid_o / out_ready_i    out_kind .. last, one or more per request
//
// A request passes the front register and the command queue before the back
// sequencer loads the result register. Send, bad frame, no-op and idle timeout
// give one result there; a good frame first frees each acknowledged frame in the
// back sequencer and then loads its result. A timeout resends each frame through
// a read state and an emit state, the read of the window store being registered.
// Reset is asynchronous; the window store is not cleared. Each side stalls on its
// own through the queue.

module go_back_n_link_control #(
  parameter int PAYLOAD_BITS = gbn_pkg::PayloadBits,
  parameter int QUEUE_DEPTH  = gbn_pkg::QueueDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              req_type_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  input  logic [2:0]              rx_seq_i,
  input  logic [2:0]              rx_ack_i,
  input  logic                    rx_crc_ok_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              out_kind_o,
  output logic [2:0]              out_seq_o,
  output logic [2:0]              out_ack_o,
  output logic [PAYLOAD_BITS-1:0] out_payload_o,
  output logic [2:0]              outstanding_count_o,
  output logic                    accept_more_o,
  output logic                    refused_o,
  output logic                    last_o
);
  import gbn_pkg::*;

  localparam int QW = $bits(cmd_t) + PAYLOAD_BITS;

  logic                    push_valid, push_ready, pop_valid, pop_ready;
  cmd_t                    f_cmd, b_cmd;
  logic [PAYLOAD_BITS-1:0] f_pay, b_pay;
  logic [QW-1:0]           q_out;
  kind_e                   kind;

  gbn_front #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .payload_i    (payload_i),
    .rx_seq_i     (rx_seq_i),
    .rx_ack_i     (rx_ack_i),
    .rx_crc_ok_i  (rx_crc_ok_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .cmd_o        (f_cmd),
    .pay_o        (f_pay)
  );

  gbn_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({f_cmd, f_pay}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (q_out)
  );

  assign b_cmd = cmd_t'(q_out[QW-1:PAYLOAD_BITS]);
  assign b_pay = q_out[PAYLOAD_BITS-1:0];

  gbn_back #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .pop_valid_i         (pop_valid),
    .pop_ready_o         (pop_ready),
    .cmd_i               (b_cmd),
    .pay_i               (b_pay),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_kind_o          (kind),
    .out_seq_o           (out_seq_o),
    .out_ack_o           (out_ack_o),
    .out_payload_o       (out_payload_o),
    .outstanding_count_o (outstanding_count_o),
    .accept_more_o       (accept_more_o),
    .refused_o           (refused_o),
    .last_o              (last_o)
  );

  assign out_kind_o = kind;

  // Only transmitted frames carry sequence and ack numbers
  a_seq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind != KIND_XMIT) |-> (out_seq_o == '0 && out_ack_o == '0))
    else $error("non-transmit result with nonzero seq/ack");

  // A refusal is a lone empty result with a full window
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && refused_o) |-> (kind == KIND_NONE && last_o && !accept_more_o))
    else $error("malformed refusal");

  // Window flag agrees with the reported count
  a_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accept_more_o == (outstanding_count_o < 3'(MaxSeq))))
    else $error("accept_more inconsistent with outstanding_count");

  // Count never exceeds the window
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outstanding_count_o <= 3'(MaxSeq)))
    else $error("outstanding count above window size");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gbn_pkg::*;

  localparam int PayW = gbn_pkg::PayloadBits;
  localparam logic [1:0] ReqUnknown = 2'd3;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 24;

  // One result as the link should emit it
  typedef struct {
    kind_e            kind;
    logic [2:0]       seq;
    logic [2:0]       ack;
    logic [PayW-1:0]  payload;
    logic [2:0]       count;
    logic             accept_more;
    logic             refused;
    logic             last;
  } link_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [1:0]      req_type = REQ_SEND;
  logic [PayW-1:0] payload = '0;
  logic [2:0]      rx_seq = '0;
  logic [2:0]      rx_ack = '0;
  logic            rx_crc_ok = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b1;
  logic [1:0]      out_kind;
  logic [2:0]      out_seq;
  logic [2:0]      out_ack;
  logic [PayW-1:0] out_payload;
  logic [2:0]      outstanding_count;
  logic            accept_more;
  logic            refused;
  logic            last;

  go_back_n_link_control u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .req_type_i          (req_type),
    .payload_i           (payload),
    .rx_seq_i            (rx_seq),
    .rx_ack_i            (rx_ack),
    .rx_crc_ok_i         (rx_crc_ok),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .out_kind_o          (out_kind),
    .out_seq_o           (out_seq),
    .out_ack_o           (out_ack),
    .out_payload_o       (out_payload),
    .outstanding_count_o (outstanding_count),
    .accept_more_o       (accept_more),
    .refused_o           (refused),
    .last_o              (last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Link state mirror: sender window, receiver position, buffered frames
  logic [2:0]      m_next_tx = '0;
  logic [2:0]      m_ack_base = '0;
  logic [2:0]      m_rx_expected = '0;
  logic [2:0]      m_in_flight = '0;
  logic [PayW-1:0] m_window [WinSlots];

  link_result_t owed_results [$];
  int unsigned  fail_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  rx_hold = 0;
  bit           tx_idle_en = 1'b1;
  bit           rx_idle_en = 1'b1;

  function automatic logic [2:0] next_seq(input logic [2:0] s);
    return (s == 3'(MaxSeq)) ? 3'd0 : s + 3'd1;
  endfunction

  // b inside the circular span starting at a and ending before c
  function automatic logic in_circ_span(input logic [2:0] a, input logic [2:0] b,
                                        input logic [2:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic int unsigned pick_wait(input bit enabled);
    if (!enabled || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Stamp window occupancy and queue one result
  task automatic owe(input link_result_t r);
    r.count       = m_in_flight;
    r.accept_more = (m_in_flight < 3'(MaxSeq));
    owed_results = {owed_results, r};
  endtask

  // Advance the link mirror by one request and queue the results it causes
  task automatic advance_link_model(input logic [1:0] rt, input logic [PayW-1:0] pay,
                                    input logic [2:0] seq, input logic [2:0] ack,
                                    input logic crc);
    link_result_t r;
    logic         deliver;
    logic [2:0]   slot;
    int unsigned  n;
    int unsigned  held;
    r.kind = KIND_NONE;
    r.seq = '0;
    r.ack = '0;
    r.payload = '0;
    r.refused = 1'b0;
    r.last = 1'b1;
    case (rt)
      REQ_SEND: begin
        if (m_in_flight >= 3'(MaxSeq)) begin
          r.refused = 1'b1;
        end else begin
          slot = m_next_tx;
          m_window[slot] = pay;
          m_in_flight = m_in_flight + 3'd1;
          m_next_tx = next_seq(slot);
          r.kind = KIND_XMIT;
          r.seq = slot;
          r.ack = m_rx_expected - 3'd1;
          r.payload = pay;
        end
        owe(r);
      end
      REQ_FRAME: begin
        if (crc) begin
          deliver = (seq == m_rx_expected);
          if (deliver) m_rx_expected = next_seq(m_rx_expected);
          // cumulative ack releases every frame up to and including ack
          while (m_in_flight != 0 && in_circ_span(m_ack_base, ack, m_next_tx)) begin
            m_in_flight = m_in_flight - 3'd1;
            m_ack_base = next_seq(m_ack_base);
          end
          if (deliver) begin
            r.kind = KIND_DELIVER;
            r.payload = pay;
          end
        end
        owe(r);
      end
      REQ_TIMEOUT: begin
        if (m_in_flight == 0) begin
          owe(r);
        end else begin
          // go back to the oldest unacked frame and resend the whole window
          held = 32'(m_in_flight);
          m_next_tx = m_ack_base;
          for (n = 0; n < held; n++) begin
            slot = m_next_tx;
            r.kind = KIND_XMIT;
            r.seq = slot;
            r.ack = m_rx_expected - 3'd1;
            r.payload = m_window[slot];
            r.last = (n + 1 == held);
            owe(r);
            m_next_tx = next_seq(slot);
          end
        end
      end
      default: owe(r);
    endcase
  endtask

  // Present one request and hold it until the link takes it; valid stays high
  task automatic send_req(input logic [1:0] rt, input logic [PayW-1:0] pay,
                          input logic [2:0] seq, input logic [2:0] ack,
                          input logic crc);
    int unsigned gap;
    gap = pick_wait(tx_idle_en);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    req_type  <= rt;
    payload   <= pay;
    rx_seq    <= seq;
    rx_ack    <= ack;
    rx_crc_ok <= crc;
    advance_link_model(rt, pay, seq, ack, crc);
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic cmp_field(input string name, input logic [PayW-1:0] want,
                           input logic [PayW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Result side: check each accepted result, then possibly stall for a random while
  always @(posedge clk_i) begin
    link_result_t w;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("result with nothing outstanding: kind %0d seq %0d payload 0x%0h",
                 out_kind, out_seq, out_payload);
          fail_cnt++;
        end else begin
          w = owed_results.pop_front();
          cmp_field("out_kind", PayW'(w.kind), PayW'(out_kind));
          cmp_field("out_seq", PayW'(w.seq), PayW'(out_seq));
          cmp_field("out_ack", PayW'(w.ack), PayW'(out_ack));
          cmp_field("out_payload", w.payload, out_payload);
          cmp_field("outstanding_count", PayW'(w.count), PayW'(outstanding_count));
          cmp_field("accept_more", PayW'(w.accept_more), PayW'(accept_more));
          cmp_field("refused", PayW'(w.refused), PayW'(refused));
          cmp_field("last", PayW'(w.last), PayW'(last));
        end
        rx_hold = pick_wait(rx_idle_en);
        if (rx_hold != 0) out_ready <= 1'b0;
      end else if (rx_hold != 0) begin
        rx_hold--;
        if (rx_hold == 0) out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Corners: empty and full window, refusal, bad CRC, out-of-order frame,
  // partial and full cumulative ack, idle timeout, unknown request
  task automatic test_protocol_corners();
    int i;
    send_req(REQ_SEND, '0, 3'd0, 3'd0, 1'b0);
    send_req(REQ_TIMEOUT, '1, 3'd7, 3'd7, 1'b1);
    send_req(REQ_FRAME, '1, 3'd0, 3'd0, 1'b0);
    send_req(REQ_FRAME, 32'h5555_5555, 3'd0, 3'd0, 1'b1);
    send_req(REQ_TIMEOUT, '0, 3'd0, 3'd0, 1'b0);
    send_req(ReqUnknown, '1, 3'd7, 3'd7, 1'b1);
    for (i = 0; i < MaxSeq; i++)
      send_req(REQ_SEND, (i % 2) ? 32'hAAAA_AAAA : '1, 3'(i), 3'(7 - i), 1'(i));
    send_req(REQ_SEND, 32'h1234_5678, 3'd0, 3'd0, 1'b0);
    send_req(REQ_TIMEOUT, '0, 3'd0, 3'd0, 1'b0);
    send_req(REQ_FRAME, 32'hDEAD_BEEF, 3'd7, 3'd3, 1'b1);
    send_req(REQ_FRAME, '1, 3'd1, 3'd7, 1'b1);
    send_req(REQ_FRAME, 32'h0F0F_0F0F, 3'd2, 3'd0, 1'b1);
    send_req(REQ_TIMEOUT, '1, 3'd0, 3'd0, 1'b1);
  endtask

  // Mostly well-formed traffic against the current window, plus noise
  task automatic test_random_traffic(input int n_items);
    int unsigned     sel;
    logic [1:0]      rt;
    logic [PayW-1:0] pay;
    logic [2:0]      seq;
    logic [2:0]      ack;
    logic            crc;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      pay = $urandom();
      seq = 3'($urandom_range(0, 7));
      ack = 3'($urandom_range(0, 7));
      crc = 1'($urandom_range(0, 1));
      if (sel < 42) begin
        rt = REQ_SEND;
      end else if (sel < 84) begin
        rt = REQ_FRAME;
        crc = 1'b1;
        if ($urandom_range(0, 9) < 7) seq = m_rx_expected;
        if (m_in_flight != 0 && $urandom_range(0, 3) != 0)
          ack = m_ack_base + 3'($urandom_range(0, m_in_flight - 1));
      end else if (sel < 93) begin
        rt = REQ_TIMEOUT;
      end else if (sel < 97) begin
        rt = REQ_FRAME;
        crc = 1'b0;
      end else begin
        rt = ReqUnknown;
      end
      send_req(rt, pay, seq, ack, crc);
    end
  endtask

  // Same traffic with neither side idling
  task automatic test_back_to_back(input int n_items);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(n_items);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_protocol_corners();
    test_random_traffic(50);
    test_back_to_back(25);
    // fast sender into a slow receiver
    tx_idle_en = 1'b0;
    test_random_traffic(20);
    tx_idle_en = 1'b1;
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && owed_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
